@@ design/plist_pkg.sv @@
// shared constants, codes and types for the positional list engine
// used by plist_cell, plist_find and positional_list_engine
`default_nettype none

package plist_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int WORD_W     = 32;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CMD_W      = 3;
  localparam int POS_W      = 5;
  localparam int ST_W       = 2;
  localparam int FIDX_W     = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

  // per-cell operation codes
  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_LOAD  = 2'd1;
  localparam logic [1:0] CELL_LEFT  = 2'd2;
  localparam logic [1:0] CELL_RIGHT = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [WORD_W-1:0] wdata;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ design/positional_list_engine.sv @@
// positional list engine: ordered list of up to LIST_DEPTH words held in a row of cells
// result is registered in the cycle after input transfer; one command per cycle unless
// stalled, set by the cell row, which shifts on insert/delete and compares all at once
// reset clears the length and the result valid; cell words stay undefined until written
// depends on plist_pkg, plist_cell, plist_find
`default_nettype none

module positional_list_engine
  import plist_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [CMD_W-1:0]         cmd,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [WORD_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [ST_W-1:0]               status,
  output logic signed [WORD_W-1:0]      read_value,
  output logic [FIDX_W-1:0]             found_index,
  output logic [CNT_W-1:0]              length_now
);

  logic                  fire;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  pos_in;
  logic                  pos_le;
  logic                  full;
  logic                  ins_ok;
  logic                  del_ok;
  logic                  upd_ok;
  logic [WORD_W-1:0]     cell_word [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] cell_match;
  logic [LIST_DEPTH-1:0] hit_vec;
  logic                  any_hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [ST_W-1:0]       status_next;
  logic [WORD_W-1:0]     read_next;
  logic [FIDX_W-1:0]     found_next;

  assign in_stall = out_valid && out_stall;
  assign fire     = in_valid && !in_stall;

  assign pos_in = (position < count);
  assign pos_le = (position <= count);
  assign full   = (count == CNT_W'(LIST_DEPTH));

  assign ins_ok = fire && (cmd == CMD_INSERT) && pos_le && !full;
  assign del_ok = fire && (cmd == CMD_DELETE) && pos_in;
  assign upd_ok = fire && (cmd == CMD_UPDATE) && pos_in;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    localparam logic [POS_W-1:0] CI = POS_W'(i);
    cell_ctl_t         ctl;
    logic [WORD_W-1:0] left_word;
    logic [WORD_W-1:0] right_word;

    always_comb begin
      ctl.op    = CELL_HOLD;
      ctl.wdata = value;
      if (ins_ok) begin
        if (CI > position) begin
          ctl.op = CELL_LEFT;
        end else if (CI == position) begin
          ctl.op = CELL_LOAD;
        end
      end else if (del_ok && (CI >= position)) begin
        ctl.op = CELL_RIGHT;
      end else if (upd_ok && (CI == position)) begin
        ctl.op = CELL_LOAD;
      end
    end

    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = cell_word[i-1];
    end

    // the last cell's right neighbor is past the end; it only matters once freed
    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_word = cell_word[i];
    end else begin : g_mid_r
      assign right_word = cell_word[i+1];
    end

    plist_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_word  (left_word),
      .right_word (right_word),
      .key        (value),
      .word       (cell_word[i]),
      .match      (cell_match[i])
    );

    assign hit_vec[i] = cell_match[i] && (CNT_W'(i) < count);
  end

  plist_find u_find (
    .hit_vec (hit_vec),
    .any_hit (any_hit),
    .hit_idx (hit_idx)
  );

  always_comb begin
    status_next = ST_OK;
    read_next   = '0;
    found_next  = '0;
    count_next  = count;
    if (fire) begin
      unique case (cmd)
        CMD_INSERT: begin
          if (!pos_le) begin
            status_next = ST_RANGE;
          end else if (full) begin
            status_next = ST_FULL;
          end else begin
            count_next = count + 1'b1;
          end
        end
        CMD_DELETE: begin
          if (!pos_in) begin
            status_next = ST_RANGE;
          end else begin
            count_next = count - 1'b1;
          end
        end
        CMD_UPDATE: begin
          if (!pos_in) begin
            status_next = ST_RANGE;
          end
        end
        CMD_GET: begin
          if (!pos_in) begin
            status_next = ST_RANGE;
          end else begin
            read_next = cell_word[position[IDX_W-1:0]];
          end
        end
        CMD_FIND: begin
          if (any_hit) begin
            found_next = FIDX_W'(hit_idx);
          end else begin
            status_next = ST_MISS;
          end
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      count <= count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status      <= status_next;
      read_value  <= read_next;
      found_index <= found_next;
      length_now  <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(LIST_DEPTH))
    else $error("list length above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ins_ok |=> (count == $past(count) + 1'b1))
    else $error("good insert did not grow the list");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL)) |-> (length_now == CNT_W'(LIST_DEPTH)))
    else $error("full status with a list that is not full");

  a_len_tracks: assert property (@(posedge clk) disable iff (rst)
    fire |=> (length_now == count))
    else $error("reported length differs from held length");
`endif

endmodule

`default_nettype wire

@@ design/plist_cell.sv @@
// one list cell: a word register that loads, holds or takes a neighbor's word
// depends on plist_pkg
`default_nettype none

module plist_cell
  import plist_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [WORD_W-1:0] left_word,
  input  wire logic [WORD_W-1:0] right_word,
  input  wire logic [WORD_W-1:0] key,
  output logic      [WORD_W-1:0] word,
  output logic                   match
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_LOAD:  word <= ctl.wdata;
      CELL_LEFT:  word <= left_word;
      CELL_RIGHT: word <= right_word;
      default:    word <= word;
    endcase
  end

  assign match = (word == key);

endmodule

`default_nettype wire

@@ design/plist_find.sv @@
// first-hit priority encoder over the cell match flags
// depends on plist_pkg
`default_nettype none

module plist_find
  import plist_pkg::*;
(
  input  wire logic [LIST_DEPTH-1:0] hit_vec,
  output logic                       any_hit,
  output logic      [IDX_W-1:0]      hit_idx
);

  always_comb begin
    hit_idx = '0;
    // scan from the top so the lowest hit wins
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign any_hit = |hit_vec;

endmodule

`default_nettype wire
